/* hw/rtl/cple_pkg.sv */
// cple_pkg: shared types, codes and defaults of the positional byte list engine.
// No dependencies; every other file of the block uses it by scoped names.

package cple_pkg;

    // Default number of stored bytes
    localparam int CAPACITY_DEF = 128;

    // Field widths fixed by the word formats
    localparam int OP_W    = 3;
    localparam int POS_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int STAT_W  = 2;

    // Item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_DELETE = 3'd4
    } t_opcode;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // What an accepted item has to do once checked
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_INSERT,
        KIND_WRITE,
        KIND_READ,
        KIND_DELETE
    } t_kind;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } t_state;

    // Memory read address select
    typedef enum logic [1:0] {
        RD_IDX,
        RD_K_DN,
        RD_K_UP
    } t_rd_sel;

    // Memory write select
    typedef enum logic {
        WR_IDX_VAL,
        WR_K_RDATA
    } t_wr_sel;

    // Shift cursor update
    typedef enum logic [2:0] {
        K_HOLD,
        K_COUNT,
        K_IDX,
        K_DEC,
        K_INC
    } t_k_op;

    // Entry count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Result data register update
    typedef enum logic [1:0] {
        D_HOLD,
        D_CLEAR,
        D_RDATA
    } t_data_op;

    // Controller to datapath commands
    typedef struct packed {
        logic     latch_in;
        logic     st_cap;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_k_op    k_op;
        t_cnt_op  cnt_op;
        t_data_op data_op;
        logic     out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  idx_at_end;
        logic  idx_last;
        logic  k_next_idx;
        logic  k_next_last;
        logic  out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/cple_in_if.sv */
// cple_in_if: input word channel of the positional byte list engine.
// Depends on cple_pkg for field widths.

interface cple_in_if;
    logic                          valid;
    logic                          ready;
    logic [cple_pkg::OP_W-1:0]     opcode;
    logic [cple_pkg::POS_W-1:0]    position;
    logic [cple_pkg::BYTE_W-1:0]   value;

    modport source (output valid, output opcode, output position, output value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input value,
                    output ready);
endinterface

/* hw/rtl/cple_out_if.sv */
// cple_out_if: result word channel of the positional byte list engine.
// Depends on cple_pkg for field widths.

interface cple_out_if;
    logic                          valid;
    logic                          ready;
    logic [cple_pkg::BYTE_W-1:0]   data_out;
    logic [cple_pkg::STAT_W-1:0]   status;
    logic [cple_pkg::CNT_W-1:0]    count;

    modport source (output valid, output data_out, output status, output count,
                    input ready);
    modport sink   (input valid, input data_out, input status, input count,
                    output ready);
endinterface

/* hw/rtl/cple_datapath.sv */
// cple_datapath: item registers, entry memory, count, shift cursor and result register.
// Depends on cple_pkg; driven by cple_ctrl through t_cmd, reports through t_dp_stat.

module cple_datapath #(
    parameter int CAPACITY = cple_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cple_pkg::t_cmd                i_cmd,
    output cple_pkg::t_dp_stat            o_stat,
    input  logic [cple_pkg::OP_W-1:0]     i_opcode,
    input  logic [cple_pkg::POS_W-1:0]    i_position,
    input  logic [cple_pkg::BYTE_W-1:0]   i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [cple_pkg::BYTE_W-1:0]   o_data_out,
    output logic [cple_pkg::STAT_W-1:0]   o_status,
    output logic [cple_pkg::CNT_W-1:0]    o_count
);
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = cple_pkg::CNT_W;
    localparam int BW  = cple_pkg::BYTE_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    // Latched item
    logic [cple_pkg::OP_W-1:0]   r_op;
    logic [cple_pkg::POS_W-1:0]  r_pos;
    logic [BW-1:0]               r_val;

    // Working state
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_k, n_k;
    cple_pkg::t_status           r_status;
    logic [BW-1:0]               r_data;

    // Entry memory
    logic [BW-1:0]               r_mem [CAPACITY];
    logic [BW-1:0]               r_rdata;

    // Result register
    logic                        r_out_valid;
    logic [BW-1:0]               r_out_data;
    logic [cple_pkg::STAT_W-1:0] r_out_status;
    logic [CW-1:0]               r_out_count;

    logic [CW-1:0]               w_idx;
    logic [CW:0]                 w_cnt9;
    logic [CW:0]                 w_pos9;
    logic                        w_full;
    logic                        w_rd_ok;
    logic                        w_ins_ok;
    cple_pkg::t_status           w_status;
    cple_pkg::t_kind             w_kind;
    logic [CW-1:0]               w_rd_addr;
    logic [CW-1:0]               w_wr_addr;
    logic [BW-1:0]               w_wr_data;

    // Capture accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= i_value;
        end
    end

    // Decode slot index and checks
    assign w_idx    = (r_op == cple_pkg::OP_PUSH) ? '0 : CW'(r_pos - 8'd1);
    assign w_cnt9   = {1'b0, r_count};
    assign w_pos9   = {1'b0, r_pos};
    assign w_full   = (r_count >= CAP);
    assign w_rd_ok  = (r_pos != '0) && (w_pos9 <= w_cnt9);
    assign w_ins_ok = (r_pos != '0) && (w_pos9 <= w_cnt9 + 9'd1);

    always_comb begin
        w_status = cple_pkg::ST_OK;
        w_kind   = cple_pkg::KIND_NONE;
        unique case (r_op)
            cple_pkg::OP_PUSH: begin
                if (w_full) begin
                    w_status = cple_pkg::ST_FULL;
                end else begin
                    w_kind = cple_pkg::KIND_INSERT;
                end
            end
            cple_pkg::OP_INSERT: begin
                if (!w_ins_ok) begin
                    w_status = cple_pkg::ST_BADPOS;
                end else if (w_full) begin
                    w_status = cple_pkg::ST_FULL;
                end else begin
                    w_kind = cple_pkg::KIND_INSERT;
                end
            end
            cple_pkg::OP_READ, cple_pkg::OP_WRITE, cple_pkg::OP_DELETE: begin
                if (r_count == '0) begin
                    w_status = cple_pkg::ST_EMPTY;
                end else if (!w_rd_ok) begin
                    w_status = cple_pkg::ST_BADPOS;
                end else if (r_op == cple_pkg::OP_READ) begin
                    w_kind = cple_pkg::KIND_READ;
                end else if (r_op == cple_pkg::OP_WRITE) begin
                    w_kind = cple_pkg::KIND_WRITE;
                end else begin
                    w_kind = cple_pkg::KIND_DELETE;
                end
            end
            default: begin
                w_status = cple_pkg::ST_OK;
                w_kind   = cple_pkg::KIND_NONE;
            end
        endcase
    end

    // Report to controller
    assign o_stat.kind        = w_kind;
    assign o_stat.idx_at_end  = (w_idx == r_count);
    assign o_stat.idx_last    = ({1'b0, w_idx} + 9'd1 >= w_cnt9);
    assign o_stat.k_next_idx  = ({1'b0, r_k} == {1'b0, w_idx} + 9'd1);
    assign o_stat.k_next_last = ({1'b0, r_k} + 9'd2 >= w_cnt9);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // Select memory addresses
    always_comb begin
        unique case (i_cmd.rd_sel)
            cple_pkg::RD_IDX:  w_rd_addr = w_idx;
            cple_pkg::RD_K_DN: w_rd_addr = r_k - 8'd1;
            cple_pkg::RD_K_UP: w_rd_addr = r_k + 8'd1;
            default:           w_rd_addr = w_idx;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            cple_pkg::WR_IDX_VAL: begin
                w_wr_addr = w_idx;
                w_wr_data = r_val;
            end
            cple_pkg::WR_K_RDATA: begin
                w_wr_addr = r_k;
                w_wr_data = r_rdata;
            end
            default: begin
                w_wr_addr = w_idx;
                w_wr_data = r_val;
            end
        endcase
    end

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr[AW-1:0]] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr[AW-1:0]];
        end
    end

    // Advance shift cursor and count
    always_comb begin
        unique case (i_cmd.k_op)
            cple_pkg::K_HOLD:  n_k = r_k;
            cple_pkg::K_COUNT: n_k = r_count;
            cple_pkg::K_IDX:   n_k = w_idx;
            cple_pkg::K_DEC:   n_k = r_k - 8'd1;
            cple_pkg::K_INC:   n_k = r_k + 8'd1;
            default:           n_k = r_k;
        endcase
        unique case (i_cmd.cnt_op)
            cple_pkg::CNT_HOLD: n_count = r_count;
            cple_pkg::CNT_INC:  n_count = r_count + 8'd1;
            cple_pkg::CNT_DEC:  n_count = r_count - 8'd1;
            default:            n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
    end

    // Hold status and data for the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.st_cap) begin
            r_status <= w_status;
        end
        unique case (i_cmd.data_op)
            cple_pkg::D_HOLD:  r_data <= r_data;
            cple_pkg::D_CLEAR: r_data <= '0;
            cple_pkg::D_RDATA: r_data <= r_rdata;
            default:           r_data <= r_data;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data   <= r_data;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

    // Count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count above capacity");

    // Writes land inside the memory
    a_wr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (w_wr_addr < CAP))
        else $error("memory write address out of range");

    // Reads only touch stored entries
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (w_rd_addr < r_count))
        else $error("memory read beyond stored entries");

endmodule

/* hw/rtl/cple_ctrl.sv */
// cple_ctrl: sequencer for checking, shifting and delivering one word at a time.
// Depends on cple_pkg; commands cple_datapath through t_cmd.

module cple_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cple_pkg::t_dp_stat   i_stat,
    output cple_pkg::t_cmd       o_cmd
);
    cple_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cple_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.latch_in   = 1'b0;
        o_cmd.st_cap     = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = cple_pkg::RD_IDX;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_sel     = cple_pkg::WR_IDX_VAL;
        o_cmd.k_op       = cple_pkg::K_HOLD;
        o_cmd.cnt_op     = cple_pkg::CNT_HOLD;
        o_cmd.data_op    = cple_pkg::D_HOLD;
        o_cmd.out_load   = 1'b0;
        unique case (r_state)
            cple_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = cple_pkg::S_DECODE;
                end
            end
            cple_pkg::S_DECODE: begin
                o_cmd.st_cap  = 1'b1;
                o_cmd.data_op = cple_pkg::D_CLEAR;
                unique case (i_stat.kind)
                    cple_pkg::KIND_INSERT: begin
                        if (i_stat.idx_at_end) begin
                            n_state = cple_pkg::S_INS_WR;
                        end else begin
                            o_cmd.k_op = cple_pkg::K_COUNT;
                            n_state    = cple_pkg::S_UP_RD;
                        end
                    end
                    cple_pkg::KIND_WRITE: begin
                        o_cmd.wr_en = 1'b1;
                        n_state     = cple_pkg::S_DONE;
                    end
                    cple_pkg::KIND_READ, cple_pkg::KIND_DELETE: begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = cple_pkg::S_RD_WAIT;
                    end
                    default: begin
                        n_state = cple_pkg::S_DONE;
                    end
                endcase
            end
            cple_pkg::S_RD_WAIT: begin
                o_cmd.data_op = cple_pkg::D_RDATA;
                if (i_stat.kind == cple_pkg::KIND_DELETE) begin
                    o_cmd.k_op = cple_pkg::K_IDX;
                    if (i_stat.idx_last) begin
                        o_cmd.cnt_op = cple_pkg::CNT_DEC;
                        n_state      = cple_pkg::S_DONE;
                    end else begin
                        n_state = cple_pkg::S_DN_RD;
                    end
                end else begin
                    n_state = cple_pkg::S_DONE;
                end
            end
            // Shift up: read entry below the cursor, then move it up
            cple_pkg::S_UP_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = cple_pkg::RD_K_DN;
                n_state      = cple_pkg::S_UP_WR;
            end
            cple_pkg::S_UP_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = cple_pkg::WR_K_RDATA;
                o_cmd.k_op   = cple_pkg::K_DEC;
                if (i_stat.k_next_idx) begin
                    n_state = cple_pkg::S_INS_WR;
                end else begin
                    n_state = cple_pkg::S_UP_RD;
                end
            end
            cple_pkg::S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = cple_pkg::WR_IDX_VAL;
                o_cmd.cnt_op = cple_pkg::CNT_INC;
                n_state      = cple_pkg::S_DONE;
            end
            // Shift down: read entry above the cursor, then move it down
            cple_pkg::S_DN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = cple_pkg::RD_K_UP;
                n_state      = cple_pkg::S_DN_WR;
            end
            cple_pkg::S_DN_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = cple_pkg::WR_K_RDATA;
                o_cmd.k_op   = cple_pkg::K_INC;
                if (i_stat.k_next_last) begin
                    o_cmd.cnt_op = cple_pkg::CNT_DEC;
                    n_state      = cple_pkg::S_DONE;
                end else begin
                    n_state = cple_pkg::S_DN_RD;
                end
            end
            // Deliver once the result register is free
            cple_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cple_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cple_pkg::S_IDLE;
            end
        endcase
    end

    // One word in flight: an accepted word drops ready until its result is loaded into the result register
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while one is in flight");

    // Never overwrite a result that has not been taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result register loaded while occupied");

    // Memory shifts and reads never overlap with a delivery
    a_no_mem_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!o_cmd.wr_en && !o_cmd.rd_en))
        else $error("memory access during result delivery");

endmodule

/* hw/rtl/char_position_list_engine.sv */
// char_position_list_engine: top level of the positional byte list engine.
// Depends on cple_pkg, cple_in_if, cple_out_if, cple_ctrl and cple_datapath.
//
//   channel  dir  modport  word fields
//   i_in     in   sink     opcode[2:0] position[7:0] value[7:0]
//   o_out    out  source   data_out[7:0] status[1:0] count[7:0]
//
// One word at a time. Each accepted word passes S_DECODE; errors, unused opcodes and
// overwrite then go to S_DONE, a read via S_RD_WAIT, a push or insert via an S_UP_RD,
// S_UP_WR pair per entry shifted up and then S_INS_WR, a delete via S_RD_WAIT and an
// S_DN_RD, S_DN_WR pair per entry shifted down. Ready returns as o_out.valid rises.
// Reset clears the entry count and the result valid flag; the memory needs no clearing.
// A stalled result holds in the output register; the next word waits in the final state.

module char_position_list_engine #(
    parameter int CAPACITY = cple_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cple_in_if.sink           i_in,
    cple_out_if.source        o_out
);
    cple_pkg::t_cmd     w_cmd;
    cple_pkg::t_dp_stat w_stat;
    logic               w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer
    cple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Storage and checks
    cple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_opcode    (i_in.opcode),
        .i_position  (i_in.position),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_data_out  (o_out.data_out),
        .o_status    (o_out.status),
        .o_count     (o_out.count)
    );

endmodule
